@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AST_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define AST_NXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define AST_IMP(lbl, clk, rst, a, b)
`define AST_NXT(lbl, clk, rst, a, b)
`endif
`endif

@@ rtl/lrgc_pkg.sv @@
// constants, register indexes and arctangent table for the range clustering core
package lrgc_pkg;

  localparam logic [26:0] ANG_TWO_PI  = 27'd105414357;
  localparam logic [26:0] ANG_PI      = 27'd52707179;
  localparam logic [26:0] ANG_HALF_PI = 27'd26353589;
  localparam logic [33:0] CORDIC_K    = 34'd652032874;
  localparam int          STEP_W      = 5;
  localparam int          ZW          = 28;
  localparam int          XW          = 34;

  typedef enum logic [2:0] {
    REG_ANGLE_START = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_RANGE_LOW   = 3'd2,
    REG_RANGE_HIGH  = 3'd3,
    REG_MIN_GAP     = 3'd4,
    REG_MAX_OBJ     = 3'd5,
    REG_DRIFT       = 3'd6
  } cfg_reg_t;

  // atan(2^-i) in 2^-24 rad
  function automatic logic [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:    v = 28'd13176795;
      5'd1:    v = 28'd7778716;
      5'd2:    v = 28'd4110060;
      5'd3:    v = 28'd2086331;
      5'd4:    v = 28'd1047214;
      5'd5:    v = 28'd524117;
      5'd6:    v = 28'd262123;
      5'd7:    v = 28'd131069;
      5'd8:    v = 28'd65536;
      5'd9:    v = 28'd32768;
      5'd10:   v = 28'd16384;
      5'd11:   v = 28'd8192;
      5'd12:   v = 28'd4096;
      5'd13:   v = 28'd2048;
      5'd14:   v = 28'd1024;
      5'd15:   v = 28'd512;
      5'd16:   v = 28'd256;
      5'd17:   v = 28'd128;
      5'd18:   v = 28'd64;
      5'd19:   v = 28'd32;
      5'd20:   v = 28'd16;
      5'd21:   v = 28'd8;
      5'd22:   v = 28'd4;
      5'd23:   v = 28'd2;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/lidar_range_gap_clustering_core.sv @@
// lidar range clustering core: scan store, run detection, cordic position unit
// Takes one range sample per request and stores it in a scan memory. A run of
// hits (strictly between the low and high range limits) closed by a miss and
// longer than the gap setting yields one object at the run's midpoint sample,
// reported as x/y in mm plus the drift offset. A sample that closes no object
// leaves the input ready for the next one. A sample that closes an object keeps
// the input stalled through one angle multiply, IW+1 compare-subtract steps of
// the angle reduction (IW = clog2(SCAN_POINTS)), a fold, CORDIC_STEPS rotations
// of the shared cordic stage and two passes through the shared output multiplier,
// and longer if the previous object still waits in the output register. The scan
// memory needs no clearing.
module lidar_range_gap_clustering_core
  import lrgc_pkg::*;
#(
  parameter int SCAN_POINTS  = 360,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [15:0]        range_mm,
  input  logic               scan_end,
  output logic               object_valid,
  input  logic               object_stall,
  output logic signed [17:0] pos_x_mm,
  output logic signed [17:0] pos_y_mm,
  output logic [3:0]         object_number,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [26:0]        cfg_data
);

`include "assert_macros.svh"

  localparam int IW = $clog2(SCAN_POINTS);
  localparam int CW = $clog2(SCAN_POINTS + 1);
  localparam int AW = IW + 28;
  localparam int KW = $clog2(IW + 1);
  localparam int PW = XW + 17;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MULT, ST_REDUCE, ST_FOLD, ST_ROTATE, ST_SCALE_X, ST_SCALE_Y, ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic signed [26:0] angle_start;
  logic [24:0]        angle_step;
  logic [15:0]        range_low_mm;
  logic [15:0]        range_high_mm;
  logic [8:0]         min_run_gap;
  logic [3:0]         max_objects;
  logic [9:0]         drift_offset_mm;

  // scan state
  logic [CW-1:0] sample_count;
  logic [IW-1:0] run_begin;
  logic          run_open;
  logic [3:0]    objects_found;
  logic          scan_pending;

  logic [15:0] scan_mem [SCAN_POINTS];
  logic [15:0] mem_rdata;

  // datapath registers
  logic [IW-1:0]        mid;
  logic signed [AW-1:0] ang;
  logic [KW-1:0]        kcnt;
  logic [STEP_W-1:0]    step;
  logic signed [ZW-1:0] z;
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;
  logic                 neg;
  logic signed [PW-1:0] prod;
  logic [17:0]          x_res;

  // request decode
  logic          accept;
  logic [IW-1:0] idx;
  logic          store_ok;
  logic          hit;
  logic          cluster_ok;
  logic          closes;
  logic [IW:0]   mid_sum;
  logic          out_load;

  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = (state == ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign idx          = sample_count[IW-1:0];
  assign store_ok     = sample_count < CW'(SCAN_POINTS);
  assign hit          = (range_mm > range_low_mm) && (range_mm < range_high_mm);
  assign cluster_ok   = store_ok && (objects_found < max_objects);
  assign closes       = cluster_ok && !hit && run_open &&
                        (32'(idx - run_begin) > 32'(min_run_gap));
  assign mid_sum      = {1'b0, run_begin} + {1'b0, idx};
  assign out_load     = (state == ST_FINISH) && (!object_valid || !object_stall);

  // angle reduction step
  logic signed [AW-1:0] two_pi_k;
  assign two_pi_k = $signed(AW'(ANG_TWO_PI) << kcnt);

  // fold into [-pi/2, pi/2]
  logic signed [AW-1:0] f1;
  logic signed [AW-1:0] f2;
  logic                 fneg;
  always_comb begin
    f1 = (ang > $signed(AW'(ANG_PI))) ? ang - $signed(AW'(ANG_TWO_PI)) : ang;
    f2 = f1;
    fneg = 1'b0;
    if (f1 > $signed(AW'(ANG_HALF_PI))) begin
      f2 = f1 - $signed(AW'(ANG_PI));
      fneg = 1'b1;
    end else if (f1 < -$signed(AW'(ANG_HALF_PI))) begin
      f2 = f1 + $signed(AW'(ANG_PI));
      fneg = 1'b1;
    end
  end

  // shared cordic rotation stage
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] at;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = $signed(atan_entry(step));

  // shared output multiplier
  logic signed [XW-1:0] mul_op;
  logic signed [PW-1:0] mul_res;
  logic signed [PW-1:0] rnd;
  logic [17:0]          scaled;
  always_comb begin
    mul_op = (state == ST_SCALE_X) ? cx : cy;
    if (neg) begin
      mul_op = -mul_op;
    end
  end
  assign mul_res = $signed({1'b0, mem_rdata}) * mul_op;
  assign rnd     = prod + $signed(PW'(1) <<< 29);
  assign scaled  = rnd[47:30] + 18'(drift_offset_mm);

  // scan memory
  always_ff @(posedge clk) begin
    if (accept && store_ok) begin
      scan_mem[idx] <= range_mm;
    end
    if (accept) begin
      mem_rdata <= scan_mem[mid_sum[IW:1]];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start     <= -27'sd52707179;
      angle_step      <= 25'd292803;
      range_low_mm    <= 16'd100;
      range_high_mm   <= 16'd3000;
      min_run_gap     <= 9'd5;
      max_objects     <= 4'd5;
      drift_offset_mm <= 10'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANGLE_START: angle_start     <= $signed(cfg_data);
        REG_ANGLE_STEP:  angle_step      <= cfg_data[24:0];
        REG_RANGE_LOW:   range_low_mm    <= cfg_data[15:0];
        REG_RANGE_HIGH:  range_high_mm   <= cfg_data[15:0];
        REG_MIN_GAP:     min_run_gap     <= cfg_data[8:0];
        REG_MAX_OBJ:     max_objects     <= cfg_data[3:0];
        REG_DRIFT:       drift_offset_mm <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sequencer, scan tracking and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sample_count  <= '0;
      run_begin     <= '0;
      run_open      <= 1'b0;
      objects_found <= '0;
      object_valid  <= 1'b0;
    end else begin
      if (object_valid && !object_stall) begin
        object_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (store_ok) begin
              sample_count <= sample_count + CW'(1);
            end
            if (cluster_ok) begin
              if (hit && !run_open) begin
                run_begin <= idx;
                run_open  <= 1'b1;
              end else if (!hit && run_open) begin
                run_open <= 1'b0;
              end
            end
            if (closes) begin
              mid   <= mid_sum[IW:1];
              state <= ST_MULT;
            end
            if (scan_end) begin
              sample_count <= '0;
              run_begin    <= '0;
              run_open     <= 1'b0;
              // a closing object clears the count once it is out
              if (!closes) begin
                objects_found <= '0;
              end
            end
          end
        end
        ST_MULT: begin
          ang   <= AW'(angle_start) + $signed(AW'(mid) * AW'(angle_step));
          kcnt  <= KW'(IW);
          state <= ST_REDUCE;
        end
        ST_REDUCE: begin
          if (ang < 0) begin
            ang <= ang + $signed(AW'(ANG_TWO_PI));
          end else if (ang >= two_pi_k) begin
            ang <= ang - two_pi_k;
          end
          if (kcnt == '0) begin
            state <= ST_FOLD;
          end else begin
            kcnt <= kcnt - KW'(1);
          end
        end
        ST_FOLD: begin
          z     <= f2[ZW-1:0];
          neg   <= fneg;
          cx    <= $signed(CORDIC_K);
          cy    <= '0;
          step  <= '0;
          state <= ST_ROTATE;
        end
        ST_ROTATE: begin
          if (z >= 0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            z  <= z - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            z  <= z + at;
          end
          if (step == STEP_W'(CORDIC_STEPS - 1)) begin
            state <= ST_SCALE_X;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_SCALE_X: begin
          prod  <= mul_res;
          state <= ST_SCALE_Y;
        end
        ST_SCALE_Y: begin
          x_res <= scaled;
          prod  <= mul_res;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            pos_x_mm      <= $signed(x_res);
            pos_y_mm      <= $signed(scaled);
            object_number <= objects_found;
            object_valid  <= 1'b1;
            state         <= ST_IDLE;
            // scan end seen with this object restarts the count
            if (scan_pending) begin
              objects_found <= '0;
            end else if (objects_found != 4'hF) begin
              objects_found <= objects_found + 4'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // remember a scan end whose closing object is still being computed
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pending <= 1'b0;
    end else if (accept) begin
      scan_pending <= scan_end && closes;
    end
  end

  `AST_IMP(a_count_bound, clk, rst, 1'b1, sample_count <= CW'(SCAN_POINTS))
  `AST_NXT(a_close_starts, clk, rst, accept && closes, state == ST_MULT)
  `AST_NXT(a_finish_loads, clk, rst, out_load, object_valid && state == ST_IDLE)

endmodule

@@ tb/lidar_range_gap_clustering_core_tb.sv @@
// testbench for the lidar range clustering core: directed and random scans with self-checking
`timescale 1ns / 100ps

module lidar_range_gap_clustering_core_tb;
  import lrgc_pkg::*;

  localparam int NPTS = 360;
  localparam int NROT = 16;
  localparam longint TWO_PI_U  = 105414357;
  localparam longint PI_U      = 52707179;
  localparam longint HALF_PI_U = 26353589;
  localparam longint GAIN_Q30  = 652032874;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic [3:0]         num;
  } object_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [15:0] range_mm = '0;
  logic scan_end = 1'b0;
  logic object_valid;
  logic object_stall = 1'b0;
  logic signed [17:0] pos_x_mm;
  logic signed [17:0] pos_y_mm;
  logic [3:0] object_number;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [26:0] cfg_data = '0;

  lidar_range_gap_clustering_core u_top (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .range_mm(range_mm), .scan_end(scan_end),
    .object_valid(object_valid), .object_stall(object_stall),
    .pos_x_mm(pos_x_mm), .pos_y_mm(pos_y_mm), .object_number(object_number),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // arctangent steps in 2^-24 rad
  localparam longint ATAN_U [0:15] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

  // predictor copy of settings and scan state
  longint      set_ang0;
  longint      set_step;
  int unsigned set_low, set_high, set_gap, set_maxobj, set_drift;
  logic [15:0] store_mm [0:NPTS-1];
  int unsigned count_pos, begin_pos, found_cnt;
  bit          in_run;

  object_t pending_objects [$];
  int errors = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL lidar_range_gap_clustering_core");
    $finish;
  end

  // rotation-mode cordic on a reduced angle
  function automatic void sin_cos_q30(input longint ang, output longint c, output longint s);
    longint r, x, y, nx;
    bit flip;
    r = ang % TWO_PI_U;
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    if (r < 0) r += TWO_PI_U;
    if (r > PI_U) r -= TWO_PI_U;
    if (r > HALF_PI_U) begin
      r -= PI_U;
      flip = 1'b1;
    end else if (r < -HALF_PI_U) begin
      r += PI_U;
      flip = 1'b1;
    end
    for (int i = 0; i < NROT; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= ATAN_U[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += ATAN_U[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [17:0] scale_mm(input logic [15:0] r, input longint q30);
    longint v;
    v = ((longint'(r) * q30 + (longint'(1) << 29)) >>> 30) + longint'(set_drift);
    return v[17:0];
  endfunction

  // advance the clustering state by one accepted sample
  task automatic cluster_sample(input logic [15:0] r, input bit last);
    bit hit;
    int unsigned mid;
    longint c, s;
    object_t o;
    if (count_pos < NPTS) begin
      hit = (r > set_low) && (r < set_high);
      store_mm[count_pos] = r;
      if (found_cnt < set_maxobj) begin
        if (hit && !in_run) begin
          begin_pos = count_pos;
          in_run = 1'b1;
        end else if (!hit && in_run) begin
          if (count_pos - begin_pos > set_gap) begin
            mid = (begin_pos + count_pos) / 2;
            sin_cos_q30(set_ang0 + longint'(mid) * set_step, c, s);
            o.x = scale_mm(store_mm[mid], c);
            o.y = scale_mm(store_mm[mid], s);
            o.num = found_cnt[3:0];
            pending_objects = {pending_objects, o};
            found_cnt++;
          end
          in_run = 1'b0;
        end
      end
      count_pos++;
    end
    if (last) begin
      count_pos = 0;
      begin_pos = 0;
      in_run = 1'b0;
      found_cnt = 0;
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // send one sample request and predict on acceptance
  task automatic send_sample(input logic [15:0] r, input bit last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      sample_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    sample_valid <= 1'b1;
    range_mm <= r;
    scan_end <= last;
    do @(posedge clk); while (sample_stall);
    cluster_sample(r, last);
    items_sent++;
  endtask

  // wait for all objects, then let the position unit settle
  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_objects.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [26:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ANGLE_START: set_ang0 = longint'($signed(d));
      REG_ANGLE_STEP:  set_step = longint'(d[24:0]);
      REG_RANGE_LOW:   set_low = d[15:0];
      REG_RANGE_HIGH:  set_high = d[15:0];
      REG_MIN_GAP:     set_gap = d[8:0];
      REG_MAX_OBJ:     set_maxobj = d[3:0];
      REG_DRIFT:       set_drift = d[9:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input longint a0, input int unsigned st, input int unsigned lo,
                         input int unsigned hi, input int unsigned gp, input int unsigned mo,
                         input int unsigned dr);
    drain();
    write_reg(REG_ANGLE_START, a0[26:0]);
    write_reg(REG_ANGLE_STEP, 27'(st));
    write_reg(REG_RANGE_LOW, 27'(lo));
    write_reg(REG_RANGE_HIGH, 27'(hi));
    write_reg(REG_MIN_GAP, 27'(gp));
    write_reg(REG_MAX_OBJ, 27'(mo));
    write_reg(REG_DRIFT, 27'(dr));
    cfg_valid <= 1'b0;
  endtask

  // range that is a hit or a miss under the current limits when possible
  function automatic logic [15:0] pick_range(input bit hit);
    if (hit) begin
      if (set_high > set_low + 1) return 16'($urandom_range(set_low + 1, set_high - 1));
      return 16'($urandom);
    end
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(0, set_low));
      1: return (set_high > 65535) ? 16'hffff : 16'($urandom_range(set_high, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // one scan of alternating hit runs and misses, closed by the scan end flag
  task automatic run_scan(input int len);
    int i, n;
    bit hit;
    i = 0;
    hit = $urandom_range(0, 1);
    while (i < len) begin
      n = hit ? $urandom_range(1, set_gap + 6) : $urandom_range(1, 3);
      repeat (n) begin
        if (i < len) send_sample(pick_range(hit), i == len - 1);
        i++;
      end
      hit = !hit;
    end
  endtask

  // object checker and output stall pattern
  initial begin
    int burst;
    bit hold;
    object_t e;
    burst = 0;
    hold = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && object_valid && !object_stall) begin
        if (pending_objects.size() == 0) begin
          $display("%0t: unexpected object x=%0d y=%0d num=%0d", $time,
                   pos_x_mm, pos_y_mm, object_number);
          errors++;
        end else begin
          e = pending_objects.pop_front();
          if (pos_x_mm !== e.x) begin
            $display("%0t: pos_x_mm expected %0d actual %0d", $time, e.x, pos_x_mm);
            errors++;
          end
          if (pos_y_mm !== e.y) begin
            $display("%0t: pos_y_mm expected %0d actual %0d", $time, e.y, pos_y_mm);
            errors++;
          end
          if (object_number !== e.num) begin
            $display("%0t: object_number expected %0d actual %0d", $time, e.num,
                     object_number);
            errors++;
          end
        end
      end
      if (burst == 0) begin
        hold = ($urandom_range(0, 2) == 0);
        burst = hold ? (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 4))
                     : $urandom_range(1, 30);
      end
      burst--;
      object_stall <= hold && !no_idle;
    end
  end

  task automatic test_default_scan();
    // run of seven closed by max range, boundary misses, run of six, open run at scan end
    logic [15:0] seq [0:24] = '{0, 101, 2999, 150, 800, 1200, 1500, 2000, 65535, 100,
                                3000, 500, 501, 502, 503, 504, 505, 99, 7, 900, 901,
                                902, 903, 904, 905};
    no_idle = 1'b1;
    for (int i = 0; i < 25; i++) send_sample(seq[i], i == 24);
    no_idle = 1'b0;
  endtask

  task automatic test_object_limit();
    set_all(0, 292803, 100, 3000, 0, 0, 0);
    run_scan(40);
    set_all(0, 292803, 100, 3000, 0, 1, 7);
    run_scan(40);
    set_all(-52707179, 100000, 100, 3000, 1, 15, 50);
    run_scan(40);
  endtask

  task automatic test_full_store();
    set_all(-52707179, 292803, 100, 3000, 5, 15, 0);
    // one long scan with short hit runs, then a run open when the store fills
    for (int i = 0; i < 340; i++) send_sample(pick_range((i % 40) >= 28), 1'b0);
    for (int i = 0; i < 30; i++) send_sample(pick_range(1), 1'b0);
    send_sample(pick_range(0), 1'b0);
    for (int i = 0; i < 10; i++) send_sample(pick_range(i % 2), i == 9);
  endtask

  task automatic test_setting_extremes();
    set_all(52707179, 16777216, 0, 65535, 0, 15, 1000);
    run_scan(40);
    set_all(-52707179, 0, 65535, 0, 0, 15, 1000);
    run_scan(30);
    set_all(0, 16777216, 1000, 1000, 0, 15, 0);
    run_scan(20);
    set_all(0, 1, 0, 65535, 511, 15, 0);
    run_scan(50);
  endtask

  task automatic test_random_scans();
    int start_items;
    start_items = items_sent;
    while (items_sent - start_items < 60) begin
      set_all($urandom_range(0, 9) == 0 ? 52707179 : longint'($urandom_range(0, 105414358))
                - 52707179,
              $urandom_range(0, 9) == 0 ? 16777216 : $urandom_range(0, 600000),
              $urandom_range(0, 2000), $urandom_range(0, 9) == 0 ? 65535
                                       : $urandom_range(1500, 20000),
              $urandom_range(0, 9), $urandom_range(0, 15),
              $urandom_range(0, 3) == 0 ? 50 : $urandom_range(0, 1000));
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) run_scan($urandom_range(8, 80));
      repeat (2) send_sample(16'($urandom), $urandom_range(0, 7) == 0);
      send_sample(16'($urandom), 1'b1);
      no_idle = 1'b0;
    end
  endtask

  initial begin
    set_ang0 = -52707179;
    set_step = 292803;
    set_low = 100;
    set_high = 3000;
    set_gap = 5;
    set_maxobj = 5;
    set_drift = 0;
    count_pos = 0;
    begin_pos = 0;
    in_run = 1'b0;
    found_cnt = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_scan();
    test_object_limit();
    test_full_store();
    test_setting_extremes();
    test_random_scans();
    drain();
    if (errors == 0) begin
      $display("PASS lidar_range_gap_clustering_core");
    end else begin
      $display("FAIL lidar_range_gap_clustering_core");
    end
    $finish;
  end

endmodule
